### rtl/rtac_pkg.sv
// Shared types, character constants and digit encoding for the radix converter.
`default_nettype none

package rtac_pkg;

    // One digit in any base up to 36, and one ASCII character.
    typedef logic [5:0] t_digit;
    typedef logic [7:0] t_char;

    // Request kinds carried in the input tuser.
    localparam logic REQ_SIGNED_DEC = 1'b0;
    localparam logic REQ_UNSIGNED   = 1'b1;

    // Base limits and the bases that get special treatment.
    localparam t_digit RADIX_MIN = 6'd2;
    localparam t_digit RADIX_MAX = 6'd36;
    localparam t_digit RADIX_DEC = 6'd10;
    localparam t_digit RADIX_OCT = 6'd8;
    localparam t_digit RADIX_HEX = 6'd16;

    // ASCII codes.
    localparam t_char CHAR_ZERO  = 8'h30;
    localparam t_char CHAR_MINUS = 8'h2D;
    localparam t_char CHAR_X     = 8'h78;
    localparam t_char CHAR_A     = 8'h61;

    // Status handed from the serial divider to the sequencer.
    typedef struct packed {
        logic   done;
        logic   quot_zero;
        t_digit digit;
    } t_div_stat;

    // Digits 0..9 map to '0'..'9', 10..35 to 'a'..'z'.
    function automatic t_char digit_char(input t_digit d);
        t_char c;
        if (d < 6'd10) begin
            c = CHAR_ZERO + {2'b00, d};
        end else begin
            c = CHAR_A + {2'b00, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/rtac_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle by a small base.
`default_nettype none

module rtac_divider #(
    parameter int VW = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VW-1:0]          i_dividend,
    input  wire rtac_pkg::t_digit       i_base,
    output logic [VW-1:0]               o_quotient,
    output rtac_pkg::t_div_stat         o_stat
);

    localparam int CW = $clog2(VW + 1);

    logic [VW-1:0]    r_dvd;
    rtac_pkg::t_digit r_rem;
    rtac_pkg::t_digit r_base;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [6:0] w_trial;
    logic       w_ge;
    logic [6:0] w_diff;

    // Bring down the next dividend bit and try one subtraction.
    assign w_trial = {r_rem, r_dvd[VW-1]};
    assign w_ge    = w_trial >= {1'b0, r_base};
    assign w_diff  = w_trial - {1'b0, r_base};

    // Control: step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register turns into the quotient bit by bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_rem  <= '0;
            r_base <= i_base;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[VW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[5:0] : w_trial[5:0];
        end
    end

    assign o_quotient       = r_dvd;
    assign o_stat.done      = r_done;
    assign o_stat.quot_zero = (r_dvd == '0);
    assign o_stat.digit     = r_rem;

endmodule

`default_nettype wire

### rtl/rtac_digit_stack.sv
// Digit store: digits are written least significant first and read back in reverse.
`default_nettype none

module rtac_digit_stack #(
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire rtac_pkg::t_digit         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output rtac_pkg::t_digit              o_rd_data
);

    rtac_pkg::t_digit r_mem [DEPTH];
    rtac_pkg::t_digit r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/radix_to_ascii_converter.sv
// Flow: an optional prefix is sent first; then each digit comes from the bit-serial divider, one quotient bit
// per cycle, and the digits are popped from the stack and sent one by one, least significant digit last.
// A new number is accepted only once the sequencer is back in idle after the last character is loaded.
// Reset: synchronous, active low; clears the sequencer, the divider control and the output valid.
`default_nettype none

module radix_to_ascii_converter #(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,  // [63:0] value, [69:64] radix, [71:70] zero
    input  wire logic        i_s_axis_tuser,  // [0] req_type
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,  // [7:0] char_code
    output logic             o_m_axis_tlast   // last
);

    localparam int VW = VALUE_WIDTH;
    localparam int CW = $clog2(VW + 1);
    localparam int AW = $clog2(VW);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PFX    = 6'b000010,
        S_DSTART = 6'b000100,
        S_DIV    = 6'b001000,
        S_READ   = 6'b010000,
        S_LOAD   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [VW-1:0]    r_val, n_val;
    rtac_pkg::t_digit r_base, n_base;
    logic [CW-1:0]    r_nd, n_nd;
    logic [1:0]       r_pfx_n, n_pfx_n;
    logic             r_neg, n_neg;
    logic             r_hex, n_hex;
    logic             r_out_valid, n_out_valid;
    rtac_pkg::t_char  r_out_char, n_out_char;
    logic             r_out_last, n_out_last;

    logic                w_accept;
    logic                w_slot_free;
    logic [VW-1:0]       w_in_val;
    logic [VW-1:0]       w_mag;
    logic                w_in_neg;
    rtac_pkg::t_digit    w_radix;
    rtac_pkg::t_digit    w_base;
    logic                w_div_start;
    logic [VW-1:0]       w_quot;
    rtac_pkg::t_div_stat w_stat;
    logic                w_wr_en;
    logic                w_rd_en;
    logic [CW-1:0]       w_nd_dec;
    rtac_pkg::t_digit    w_rd_digit;
    rtac_pkg::t_char     w_pfx_char;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_nd_dec    = r_nd - CW'(1);

    // Decode the incoming word: magnitude, sign and clamped base.
    assign w_in_val = i_s_axis_tdata[VW-1:0];
    assign w_radix  = i_s_axis_tdata[69:64];
    assign w_in_neg = (i_s_axis_tuser == rtac_pkg::REQ_SIGNED_DEC) && w_in_val[VW-1];
    assign w_mag    = w_in_neg ? (~w_in_val + VW'(1)) : w_in_val;

    always_comb begin
        if (i_s_axis_tuser == rtac_pkg::REQ_SIGNED_DEC) begin
            w_base = rtac_pkg::RADIX_DEC;
        end else if (w_radix < rtac_pkg::RADIX_MIN) begin
            w_base = rtac_pkg::RADIX_MIN;
        end else if (w_radix > rtac_pkg::RADIX_MAX) begin
            w_base = rtac_pkg::RADIX_MAX;
        end else begin
            w_base = w_radix;
        end
    end

    // Prefix character: the last pending one is '-', '0' or 'x'.
    always_comb begin
        if (r_pfx_n == 2'd2) begin
            w_pfx_char = rtac_pkg::CHAR_ZERO;
        end else if (r_neg) begin
            w_pfx_char = rtac_pkg::CHAR_MINUS;
        end else if (r_hex) begin
            w_pfx_char = rtac_pkg::CHAR_X;
        end else begin
            w_pfx_char = rtac_pkg::CHAR_ZERO;
        end
    end

    // Sequencer: prefix, repeated division, then digits popped in reverse.
    always_comb begin
        n_state     = r_state;
        n_val       = r_val;
        n_base      = r_base;
        n_nd        = r_nd;
        n_pfx_n     = r_pfx_n;
        n_neg       = r_neg;
        n_hex       = r_hex;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_div_start = 1'b0;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_val  = w_mag;
                    n_base = w_base;
                    n_nd   = '0;
                    n_neg  = w_in_neg;
                    n_hex  = (i_s_axis_tuser == rtac_pkg::REQ_UNSIGNED) &&
                             (w_base == rtac_pkg::RADIX_HEX);
                    if (w_in_neg) begin
                        n_pfx_n = 2'd1;
                    end else if (i_s_axis_tuser == rtac_pkg::REQ_UNSIGNED &&
                                 w_base == rtac_pkg::RADIX_HEX) begin
                        n_pfx_n = 2'd2;
                    end else if (i_s_axis_tuser == rtac_pkg::REQ_UNSIGNED &&
                                 w_base == rtac_pkg::RADIX_OCT) begin
                        n_pfx_n = 2'd1;
                    end else begin
                        n_pfx_n = 2'd0;
                    end
                    n_state = (n_pfx_n == 2'd0) ? S_DSTART : S_PFX;
                end
            end
            S_PFX: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_pfx_char;
                    n_out_last  = 1'b0;
                    n_pfx_n     = r_pfx_n - 2'd1;
                    if (r_pfx_n == 2'd1) begin
                        n_state = S_DSTART;
                    end
                end
            end
            S_DSTART: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_stat.done) begin
                    w_wr_en = 1'b1;
                    n_nd    = r_nd + CW'(1);
                    n_val   = w_quot;
                    n_state = w_stat.quot_zero ? S_READ : S_DSTART;
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_nd    = w_nd_dec;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = rtac_pkg::digit_char(w_rd_digit);
                    n_out_last  = (r_nd == '0);
                    n_state     = (r_nd == '0) ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nd        <= '0;
            r_pfx_n     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nd        <= n_nd;
            r_pfx_n     <= n_pfx_n;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_base     <= n_base;
        r_neg      <= n_neg;
        r_hex      <= n_hex;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    rtac_divider #(
        .VW(VW)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(r_val),
        .i_base    (r_base),
        .o_quotient(w_quot),
        .o_stat    (w_stat)
    );

    rtac_digit_stack #(
        .DEPTH(VW)
    ) u_stack (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_nd[AW-1:0]),
        .i_wr_data(w_stat.digit),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_nd_dec[AW-1:0]),
        .o_rd_data(w_rd_digit)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

    // The digit count never exceeds the stack depth.
    a_nd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nd <= CW'(VW))
        else $error("digit count beyond stack depth");

    // A division only completes while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the division state");

    // A number is accepted only with an empty digit stack.
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_nd == '0))
        else $error("word accepted with digits pending");

    // After the final character is loaded the sequencer is idle again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && w_slot_free && r_nd == '0) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the last character");

endmodule

`default_nettype wire

### tb/tb_radix_to_ascii_converter.sv
`timescale 1ns / 1ps
// Self-checking testbench: numbers in, checked ASCII characters out of the radix converter.
module tb_radix_to_ascii_converter;

    localparam int VALUE_WIDTH   = 64;
    localparam int N_RANDOM      = 100;
    localparam int SETTLE_CYCLES = 300;
    // Worst case per number is 64 characters, each of which may be stalled.
    localparam int CYCLE_LIMIT   = 4_000_000;

    // One number to convert, plus a flag that holds it back until all characters are out.
    typedef struct {
        logic                   req_type;
        logic [VALUE_WIDTH-1:0] value;
        rtac_pkg::t_digit       radix;
        logic                   drain_first;
    } t_number_req;

    // One character that the converter should emit.
    typedef struct {
        rtac_pkg::t_char code;
        logic            last;
    } t_char_exp;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [71:0] in_tdata = '0;  // [63:0] value, [69:64] radix, [71:70] zero
    logic        in_tuser = 1'b0;  // [0] req_type
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_tdata;  // [7:0] char_code
    logic        out_tlast;

    t_number_req pending_numbers[$];
    t_char_exp   expected_chars[$];
    logic        word_taken     = 1'b0;
    int          send_gap       = 0;
    int          sink_stall     = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    radix_to_ascii_converter #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(in_valid),
        .o_s_axis_tready(in_ready),
        .i_s_axis_tdata (in_tdata),
        .i_s_axis_tuser (in_tuser),
        .o_m_axis_tvalid(out_valid),
        .i_m_axis_tready(out_ready),
        .o_m_axis_tdata (out_tdata),
        .o_m_axis_tlast (out_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Appends the characters that spell one number to the expected stream.
    function automatic void predict_number_chars(input logic req_type,
                                                 input logic [VALUE_WIDTH-1:0] value,
                                                 input rtac_pkg::t_digit radix_field);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] base;
        logic [VALUE_WIDTH-1:0] digit;
        rtac_pkg::t_char        spelled[$];
        rtac_pkg::t_char        digit_chars[$];
        t_char_exp              item;
        mag  = value;
        base = VALUE_WIDTH'(rtac_pkg::RADIX_DEC);
        if (req_type == rtac_pkg::REQ_SIGNED_DEC) begin
            // Negation of the most negative value wraps to 2^63, read as unsigned.
            if (mag[VALUE_WIDTH-1]) begin
                spelled.push_back(rtac_pkg::CHAR_MINUS);
                mag = -mag;
            end
        end else begin
            if (radix_field < rtac_pkg::RADIX_MIN) begin
                base = VALUE_WIDTH'(rtac_pkg::RADIX_MIN);
            end else if (radix_field > rtac_pkg::RADIX_MAX) begin
                base = VALUE_WIDTH'(rtac_pkg::RADIX_MAX);
            end else begin
                base = VALUE_WIDTH'(radix_field);
            end
            if (base == VALUE_WIDTH'(rtac_pkg::RADIX_OCT)) begin
                spelled.push_back(rtac_pkg::CHAR_ZERO);
            end else if (base == VALUE_WIDTH'(rtac_pkg::RADIX_HEX)) begin
                spelled.push_back(rtac_pkg::CHAR_ZERO);
                spelled.push_back(rtac_pkg::CHAR_X);
            end
        end
        // Least significant digit comes out of the division first.
        do begin
            digit = mag % base;
            mag   = mag / base;
            if (digit < 10) begin
                digit_chars.push_front(rtac_pkg::CHAR_ZERO + rtac_pkg::t_char'(digit));
            end else begin
                digit_chars.push_front(rtac_pkg::CHAR_A + rtac_pkg::t_char'(digit - 10));
            end
        end while (mag != 0);
        foreach (digit_chars[k]) spelled.push_back(digit_chars[k]);
        foreach (spelled[k]) begin
            item.code = spelled[k];
            item.last = (k == spelled.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    // Idle lengths: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Values spread over full width, short magnitudes, single bits and large negatives.
    function automatic logic [VALUE_WIDTH-1:0] random_value();
        logic [VALUE_WIDTH-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v;
            1: v = v >> $urandom_range(1, 63);
            2: v = VALUE_WIDTH'($urandom_range(0, 40));
            3: v = VALUE_WIDTH'(1) << $urandom_range(0, 63);
            4: v = ~(v >> $urandom_range(1, 63));
            default: v = v >> $urandom_range(32, 63);
        endcase
        return v;
    endfunction

    // Mostly legal bases, with octal and hex favored and some out-of-range codes.
    function automatic rtac_pkg::t_digit random_radix();
        case ($urandom_range(0, 7))
            0: return rtac_pkg::t_digit'($urandom_range(0, 63));
            1: return rtac_pkg::RADIX_OCT;
            2: return rtac_pkg::RADIX_HEX;
            default: return rtac_pkg::t_digit'($urandom_range(2, 36));
        endcase
    endfunction

    task automatic add_number(input logic req_type, input logic [VALUE_WIDTH-1:0] value,
                              input rtac_pkg::t_digit radix, input logic drain_first);
        t_number_req req;
        req.req_type    = req_type;
        req.value       = value;
        req.radix       = radix;
        req.drain_first = drain_first;
        pending_numbers.push_back(req);
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Sender: presents the next word at the falling edge once the last one was taken.
    always @(negedge i_clk) begin
        t_number_req req;
        logic        next_valid;
        if (i_rst_n) begin
            next_valid = in_valid;
            if (!in_valid || word_taken) begin
                next_valid = 1'b0;
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_numbers.size() != 0 &&
                             !(pending_numbers[0].drain_first &&
                               expected_chars.size() != 0)) begin
                    req = pending_numbers.pop_front();
                    in_tdata   <= {2'b00, req.radix, req.value};
                    in_tuser   <= req.req_type;
                    next_valid = 1'b1;
                    send_gap   = pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver: random stalls on the output side.
    always @(negedge i_clk) begin
        if (sink_stall > 0) begin
            out_ready <= 1'b0;
            sink_stall--;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) sink_stall = pick_gap();
        end
    end

    // Monitor: checks each output word, then predicts from each accepted input word.
    always @(posedge i_clk) begin
        t_char_exp want;
        if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_chars.size() == 0) begin
                    flag_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                            out_tdata, out_tlast));
                end else begin
                    want = expected_chars.pop_front();
                    if (out_tdata !== want.code || out_tlast !== want.last) begin
                        flag_mismatch($sformatf(
                            "char mismatch: expected 0x%02h last %0b, got 0x%02h last %0b",
                            want.code, want.last, out_tdata, out_tlast));
                    end
                end
            end
            word_taken = in_valid && in_ready;
            if (word_taken) predict_number_chars(in_tuser, in_tdata[63:0], in_tdata[69:64]);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL radix_to_ascii_converter");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial begin
        // Signed decimal: zero, one, minus one, the extremes, and an ignored radix field.
        add_number(rtac_pkg::REQ_SIGNED_DEC, 64'd0, rtac_pkg::RADIX_DEC, 1'b0);
        add_number(rtac_pkg::REQ_SIGNED_DEC, 64'd1, 6'd0, 1'b0);
        add_number(rtac_pkg::REQ_SIGNED_DEC, '1, 6'd63, 1'b0);
        add_number(rtac_pkg::REQ_SIGNED_DEC, 64'h7FFF_FFFF_FFFF_FFFF, rtac_pkg::RADIX_HEX,
                   1'b0);
        add_number(rtac_pkg::REQ_SIGNED_DEC, 64'h8000_0000_0000_0000, rtac_pkg::RADIX_OCT,
                   1'b0);
        add_number(rtac_pkg::REQ_SIGNED_DEC, -64'sd10, rtac_pkg::RADIX_DEC, 1'b0);
        add_number(rtac_pkg::REQ_SIGNED_DEC, 64'd9, rtac_pkg::RADIX_MIN, 1'b0);
        // Unsigned: radix codes below two get clamped.
        add_number(rtac_pkg::REQ_UNSIGNED, '1, 6'd0, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd5, 6'd1, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd0, rtac_pkg::RADIX_MIN, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'h8000_0000_0000_0000, rtac_pkg::RADIX_MIN,
                   1'b0);
        // Octal and hex zero keep their prefixes; then other bases, and codes above thirty-six that get clamped.
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd0, rtac_pkg::RADIX_OCT, 1'b1);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'o777, rtac_pkg::RADIX_OCT, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd0, rtac_pkg::RADIX_HEX, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, '1, rtac_pkg::RADIX_HEX, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'hABCD_EF01, rtac_pkg::RADIX_HEX, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, '1, rtac_pkg::RADIX_DEC, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd35, rtac_pkg::RADIX_MAX, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, '1, rtac_pkg::RADIX_MAX, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd36, 6'd37, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'h5555_5555_5555_5555, 6'd63, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd100, 6'd3, 1'b0);
        add_number(rtac_pkg::REQ_UNSIGNED, 64'd1, 6'd21, 1'b0);
        repeat (N_RANDOM) begin
            add_number(logic'($urandom_range(0, 1)), random_value(), random_radix(),
                       $urandom_range(0, 19) == 0);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("PASS radix_to_ascii_converter");
        end else begin
            $display("FAIL radix_to_ascii_converter");
        end
        $finish;
    end

endmodule

### radix_to_ascii_converter.f
rtl/rtac_pkg.sv
rtl/rtac_divider.sv
rtl/rtac_digit_stack.sv
rtl/radix_to_ascii_converter.sv
tb/tb_radix_to_ascii_converter.sv
